FILE: hw/rtl/fccf_pkg.sv
// Shared types and constants for the FAT12 cluster chain follower.
// No dependencies; imported by the controller, datapath, top level and checker.
`default_nettype none

package fccf_pkg;

  localparam int unsigned ADDR_W    = 13;
  localparam int unsigned CLUSTER_W = 12;

  localparam logic [CLUSTER_W-1:0] END_MARK   = 12'hFF8;
  localparam logic [CLUSTER_W-1:0] ENTRY_MASK = 12'hFFF;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_START   = 2'd1,
    FUNC_ADVANCE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic mem_we;      // write table byte from the input beat
    logic cap_first;   // probe <= first cluster
    logic cap_cur;     // probe <= current cluster
    logic err_result;  // error result, close chain
    logic eval_next;   // probe <= entry of probe
    logic eval_start;  // start result from probe entry
    logic eval_adv;    // advance result from probe entry
    logic out_load;    // result -> output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic chain_open;
    logic first_bad;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fccf_ctrl.sv
// Controller for the FAT12 cluster chain follower: sequences table reads
// and result handoff. Depends on fccf_pkg.
`default_nettype none

module fccf_ctrl
  import fccf_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire logic [1:0] func_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   adv_q, adv_d;
  logic   second_q, second_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      adv_q       <= 1'b0;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      adv_q       <= adv_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state
  always_comb begin
    state_d  = state_q;
    adv_d    = adv_q;
    second_d = second_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (func_i)
            FUNC_START: begin
              adv_d    = 1'b0;
              second_d = 1'b0;
              state_d  = sts_i.first_bad ? ST_DONE : ST_READ;
            end
            FUNC_ADVANCE: begin
              adv_d    = 1'b1;
              second_d = 1'b0;
              state_d  = sts_i.chain_open ? ST_READ : ST_DONE;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_d = ST_EVAL;
      ST_EVAL: begin
        if (adv_q && !second_q) begin
          second_d = 1'b1;
          state_d  = ST_READ;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (func_i)
            FUNC_LOAD:    cmd_o.mem_we = 1'b1;
            FUNC_START: begin
              cmd_o.err_result = sts_i.first_bad;
              cmd_o.cap_first  = !sts_i.first_bad;
            end
            FUNC_ADVANCE: begin
              cmd_o.err_result = !sts_i.chain_open;
              cmd_o.cap_cur    = sts_i.chain_open;
            end
            default: ;
          endcase
        end
      end
      ST_READ: ;
      ST_EVAL: begin
        if (adv_q && !second_q) cmd_o.eval_next = 1'b1;
        else if (adv_q)         cmd_o.eval_adv  = 1'b1;
        else                    cmd_o.eval_start = 1'b1;
      end
      ST_DONE: cmd_o.out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.out_load;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: hw/rtl/fccf_dp.sv
// Datapath for the FAT12 cluster chain follower: table memory, entry decode,
// chain registers and output register. Depends on fccf_pkg.
`default_nettype none

module fccf_dp
  import fccf_pkg::*;
#(
  parameter int unsigned TABLE_BYTES = 8192
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dp_cmd_t              cmd_i,
  output dp_sts_t                   sts_o,
  input  wire logic [ADDR_W-1:0]    byte_address_i,
  input  wire logic [7:0]           byte_value_i,
  input  wire logic [CLUSTER_W-1:0] first_cluster_i,
  output logic [CLUSTER_W-1:0]      cluster_o,
  output logic [CLUSTER_W-1:0]      chain_index_o,
  output logic                      is_last_o,
  output logic                      error_o
);

  localparam int unsigned AW = $clog2(TABLE_BYTES);
  localparam logic [ADDR_W:0] DepthLim = (ADDR_W+1)'(TABLE_BYTES);

  logic [7:0] mem_q [TABLE_BYTES];

  logic [CLUSTER_W-1:0] probe_q, cur_q, pos_q;
  logic                 open_q;
  logic [CLUSTER_W-1:0] res_cluster_q, res_index_q;
  logic                 res_last_q, res_err_q;
  logic [CLUSTER_W-1:0] out_cluster_q, out_index_q;
  logic                 out_last_q, out_err_q;

  logic [ADDR_W-1:0]    off_lo, off_hi;
  logic                 lo_ok, hi_ok, wr_ok;
  logic [7:0]           rd_lo_q, rd_hi_q;
  logic                 lo_ok_q, hi_ok_q;
  logic [15:0]          word;
  logic [15:0]          shifted;
  logic [CLUSTER_W-1:0] entry;
  logic                 entry_last;
  logic [CLUSTER_W-1:0] pos_inc;

  // entry of cluster c lives at byte c + c/2
  assign off_lo = ADDR_W'(probe_q) + ADDR_W'(probe_q[CLUSTER_W-1:1]);
  assign off_hi = off_lo + ADDR_W'(1);
  assign lo_ok  = {1'b0, off_lo} < DepthLim;
  assign hi_ok  = {1'b0, off_hi} < DepthLim;
  assign wr_ok  = {1'b0, byte_address_i} < DepthLim;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we && wr_ok) mem_q[byte_address_i[AW-1:0]] <= byte_value_i;
    rd_lo_q <= mem_q[off_lo[AW-1:0]];
    rd_hi_q <= mem_q[off_hi[AW-1:0]];
    lo_ok_q <= lo_ok;
    hi_ok_q <= hi_ok;
  end

  // bytes past the table read as zero
  assign word       = {hi_ok_q ? rd_hi_q : 8'h00, lo_ok_q ? rd_lo_q : 8'h00};
  assign shifted    = probe_q[0] ? (word >> 4) : word;
  assign entry      = shifted[CLUSTER_W-1:0] & ENTRY_MASK;
  assign entry_last = entry >= END_MARK;
  assign pos_inc    = pos_q + CLUSTER_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      pos_q  <= '0;
      open_q <= 1'b0;
    end else begin
      if (cmd_i.err_result) open_q <= 1'b0;
      if (cmd_i.eval_start) begin
        cur_q  <= probe_q;
        pos_q  <= '0;
        open_q <= !entry_last;
      end
      if (cmd_i.eval_adv) begin
        cur_q  <= probe_q;
        pos_q  <= pos_inc;
        open_q <= !entry_last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_first) probe_q <= first_cluster_i;
    if (cmd_i.cap_cur)   probe_q <= cur_q;
    if (cmd_i.eval_next) probe_q <= entry;
    if (cmd_i.err_result) begin
      res_cluster_q <= '0;
      res_index_q   <= '0;
      res_last_q    <= 1'b0;
      res_err_q     <= 1'b1;
    end
    if (cmd_i.eval_start || cmd_i.eval_adv) begin
      res_cluster_q <= probe_q;
      res_index_q   <= cmd_i.eval_adv ? pos_inc : '0;
      res_last_q    <= entry_last;
      res_err_q     <= 1'b0;
    end
    if (cmd_i.out_load) begin
      out_cluster_q <= res_cluster_q;
      out_index_q   <= res_index_q;
      out_last_q    <= res_last_q;
      out_err_q     <= res_err_q;
    end
  end

  assign sts_o.chain_open = open_q;
  assign sts_o.first_bad  = (first_cluster_i == '0) || (first_cluster_i >= END_MARK);

  assign cluster_o     = out_cluster_q;
  assign chain_index_o = out_index_q;
  assign is_last_o     = out_last_q;
  assign error_o       = out_err_q;

endmodule

`default_nettype wire

FILE: hw/rtl/fat12_cluster_chain_follower.sv
// FAT12 cluster chain follower, top level. Depends on fccf_pkg, fccf_ctrl, fccf_dp.
// Load: the next beat may follow at once; after start or advance it waits for IDLE.
// Start: a table read (READ, EVAL), then DONE; a bad first cluster skips to DONE.
// Advance: two dependent synchronous table reads, then DONE; a closed chain skips them.
// A held output beat delays only the final handoff; the table is not cleared by reset.
// Reset (rst_ni low, async) closes any chain and zeroes the current cluster and index.
`default_nettype none

module fat12_cluster_chain_follower
  import fccf_pkg::*;
#(
  parameter int unsigned TABLE_BYTES = 8192
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           func_i,
  input  wire logic [ADDR_W-1:0]    byte_address_i,
  input  wire logic [7:0]           byte_value_i,
  input  wire logic [CLUSTER_W-1:0] first_cluster_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [CLUSTER_W-1:0]      cluster_o,
  output logic [CLUSTER_W-1:0]      chain_index_o,
  output logic                      is_last_o,
  output logic                      error_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  fccf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fccf_dp #(
    .TABLE_BYTES (TABLE_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .byte_address_i  (byte_address_i),
    .byte_value_i    (byte_value_i),
    .first_cluster_i (first_cluster_i),
    .cluster_o       (cluster_o),
    .chain_index_o   (chain_index_o),
    .is_last_o       (is_last_o),
    .error_o         (error_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/fccf_checker.sv
// Port-level checker for the FAT12 cluster chain follower, bound to the top level.
// Depends on fccf_pkg.
`default_nettype none

module fccf_checker
  import fccf_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire logic [1:0]           func_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic [CLUSTER_W-1:0] cluster_o,
  input wire logic [CLUSTER_W-1:0] chain_index_o,
  input wire logic                 is_last_o,
  input wire logic                 error_o
);

  // held output beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cluster_o)
      && $stable(chain_index_o) && $stable(is_last_o) && $stable(error_o))
    else $error("output beat changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> cluster_o == '0 && chain_index_o == '0 && !is_last_o)
    else $error("error beat carries nonzero fields");

  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && func_i == FUNC_LOAD |=> in_ready_o)
    else $error("load did not complete in one cycle");

  // a start or advance never finishes in the cycle right after its accept
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (func_i == FUNC_START || func_i == FUNC_ADVANCE)
      |=> !in_ready_o)
    else $error("ready returned before result was produced");

endmodule

bind fat12_cluster_chain_follower fccf_checker u_fccf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .func_i        (func_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .cluster_o     (cluster_o),
  .chain_index_o (chain_index_o),
  .is_last_o     (is_last_o),
  .error_o       (error_o)
);

`default_nettype wire
